### hw/rtl/csvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvf_pkg
// Shared types, codes and helpers of the cascaded state-variable filter.
// ----------------------------------------------------------------------------
package csvf_pkg;

    // section values are signed 32 bit, intermediate sums carry two guard bits
    localparam int DATA_W    = 32;
    localparam int SUM_W     = 34;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TYPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_F      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Q      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Q_SQRT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd5;

    // output tap
    localparam logic [1:0] FT_LOW   = 2'd0;
    localparam logic [1:0] FT_HIGH  = 2'd1;
    localparam logic [1:0] FT_BAND  = 2'd2;
    localparam logic [1:0] FT_NOTCH = 2'd3;

    // multiplier operand pairs
    localparam logic [2:0] MUL_F_BAND  = 3'd0;
    localparam logic [2:0] MUL_QS_X    = 3'd1;
    localparam logic [2:0] MUL_Q_BAND  = 3'd2;
    localparam logic [2:0] MUL_F_HIGH  = 3'd3;
    localparam logic [2:0] MUL_GAIN    = 3'd4;

    // datapath update operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOW   = 3'd1;
    localparam logic [2:0] OP_XSCL  = 3'd2;
    localparam logic [2:0] OP_HIGH  = 3'd3;
    localparam logic [2:0] OP_NOTCH = 3'd4;
    localparam logic [2:0] OP_BAND  = 3'd5;

    typedef struct packed {
        logic       load_x;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic [2:0] op;
        logic       out_load;
    } t_dp_cmd;

    localparam logic signed [SUM_W-1:0] D_MAX = 34'sd2147483647;
    localparam logic signed [SUM_W-1:0] D_MIN = -34'sd2147483648;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > D_MAX) begin
            res = D_MAX[DATA_W-1:0];
        end else if (v < D_MIN) begin
            res = D_MIN[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [SUM_W-1:0] sx(input logic signed [DATA_W-1:0] v);
        return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage

### hw/rtl/csvf_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvf_regs
// Configuration registers, stage count decode and section clear strobe.
// ----------------------------------------------------------------------------
module csvf_regs import csvf_pkg::*; #(
    parameter int STAGES    = 5,
    parameter int IDX_W     = 3,
    parameter int COEF_BITS = 18
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                       i_cfg_index,
    input  logic [((COEF_BITS > 16) ? COEF_BITS : 16)-1:0] i_cfg_data,
    output logic [1:0]                                 o_filter_type,
    output logic [IDX_W-1:0]                           o_last_stage,
    output logic [COEF_BITS-1:0]                       o_coef_f,
    output logic [COEF_BITS-1:0]                       o_coef_q,
    output logic [COEF_BITS-1:0]                       o_coef_q_sqrt,
    output logic [GAIN_W-1:0]                          o_gain,
    output logic                                       o_clear
);

    localparam logic [COEF_BITS-1:0] F_RST  = COEF_BITS'((64'd26214 << COEF_BITS) >> 18);
    localparam logic [COEF_BITS-1:0] Q_RST  = COEF_BITS'((64'd131072 << COEF_BITS) >> 18);
    localparam logic [COEF_BITS-1:0] QS_RST = COEF_BITS'((64'd185364 << COEF_BITS) >> 18);
    localparam logic [COEF_BITS-1:0] F_LIM  = COEF_BITS'((64'd1 << COEF_BITS) - 64'd3);

    logic [1:0]           r_filter_type;
    logic [2:0]           r_stage_count;
    logic [COEF_BITS-1:0] r_coef_f;
    logic [COEF_BITS-1:0] r_coef_q;
    logic [COEF_BITS-1:0] r_coef_q_sqrt;
    logic [GAIN_W-1:0]    r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_type <= FT_LOW;
            r_stage_count <= 3'd1;
            r_coef_f      <= F_RST;
            r_coef_q      <= Q_RST;
            r_coef_q_sqrt <= QS_RST;
            r_gain        <= GAIN_W'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FILTER_TYPE: r_filter_type <= i_cfg_data[1:0];
                REG_STAGE_COUNT: r_stage_count <= i_cfg_data[2:0];
                REG_COEF_F:      r_coef_f      <= i_cfg_data[COEF_BITS-1:0];
                REG_COEF_Q:      r_coef_q      <= i_cfg_data[COEF_BITS-1:0];
                REG_COEF_Q_SQRT: r_coef_q_sqrt <= i_cfg_data[COEF_BITS-1:0];
                REG_GAIN:        r_gain        <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_stage_count == 3'd0) begin
            o_last_stage = '0;
        end else if (int'(r_stage_count) > STAGES) begin
            o_last_stage = IDX_W'(STAGES - 1);
        end else begin
            o_last_stage = IDX_W'(r_stage_count - 3'd1);
        end
    end

    assign o_clear       = i_cfg_we && (i_cfg_index == REG_STAGE_COUNT);
    assign o_filter_type = r_filter_type;
    assign o_coef_f      = (r_coef_f > F_LIM) ? F_LIM : r_coef_f;
    assign o_coef_q      = r_coef_q;
    assign o_coef_q_sqrt = r_coef_q_sqrt;
    assign o_gain        = r_gain;

endmodule

### hw/rtl/csvf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvf_ctrl
// Sequencer: steps each section through six steps on the shared multiplier,
// then the gain product, and manages the input and output handshakes.
// ----------------------------------------------------------------------------
module csvf_ctrl import csvf_pkg::*; #(
    parameter int IDX_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  logic [IDX_W-1:0] i_last_stage,
    output logic [IDX_W-1:0] o_stage,
    output t_dp_cmd          o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEC  = 2'd1;
    localparam logic [1:0] S_GMUL = 2'd2;
    localparam logic [1:0] S_GOUT = 2'd3;

    localparam logic [2:0] ST_F_BAND = 3'd0;
    localparam logic [2:0] ST_LOW    = 3'd1;
    localparam logic [2:0] ST_XSCL   = 3'd2;
    localparam logic [2:0] ST_HIGH   = 3'd3;
    localparam logic [2:0] ST_NOTCH  = 3'd4;
    localparam logic [2:0] ST_BAND   = 3'd5;

    logic [1:0]       r_state, n_state;
    logic [2:0]       r_step, n_step;
    logic [IDX_W-1:0] r_stage, n_stage;
    logic             r_out_valid, n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_stage     = r_stage;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '{load_x: 1'b0, mul_en: 1'b0, mul_sel: MUL_F_BAND,
                        op: OP_NONE, out_load: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_x = 1'b1;
                    n_state      = S_SEC;
                    n_step       = ST_F_BAND;
                    n_stage      = '0;
                end
            end
            S_SEC: begin
                n_step = r_step + 3'd1;
                unique case (r_step)
                    ST_F_BAND: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_F_BAND;
                    end
                    ST_LOW: begin
                        o_cmd.op      = OP_LOW;
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_QS_X;
                    end
                    ST_XSCL: begin
                        o_cmd.op      = OP_XSCL;
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_Q_BAND;
                    end
                    ST_HIGH: begin
                        o_cmd.op = OP_HIGH;
                    end
                    ST_NOTCH: begin
                        o_cmd.op      = OP_NOTCH;
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_F_HIGH;
                    end
                    ST_BAND: begin
                        o_cmd.op = OP_BAND;
                        n_step   = ST_F_BAND;
                        if (r_stage == i_last_stage) begin
                            n_state = S_GMUL;
                        end else begin
                            n_stage = r_stage + IDX_W'(1);
                        end
                    end
                    default: begin
                        n_step = ST_F_BAND;
                    end
                endcase
            end
            S_GMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GAIN;
                n_state       = S_GOUT;
            end
            S_GOUT: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_F_BAND;
            r_stage     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_stage     = r_stage;

endmodule

### hw/rtl/csvf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvf_dp
// Datapath: section state, one shared multiplier with registered product,
// rounding, saturation, tap select and the output register.
// ----------------------------------------------------------------------------
module csvf_dp import csvf_pkg::*; #(
    parameter int STAGES      = 5,
    parameter int IDX_W       = 3,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  logic [IDX_W-1:0]              i_stage,
    input  logic                          i_clear,
    input  logic [1:0]                    i_filter_type,
    input  logic [COEF_BITS-1:0]          i_coef_f,
    input  logic [COEF_BITS-1:0]          i_coef_q,
    input  logic [COEF_BITS-1:0]          i_coef_q_sqrt,
    input  logic [GAIN_W-1:0]             i_gain,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_clipped
);

    localparam int MA_W = (COEF_BITS > GAIN_W) ? COEF_BITS : GAIN_W;
    localparam int P_W  = MA_W + DATA_W + 1;

    localparam logic signed [P_W-1:0] HALF_C  = P_W'(1) << (COEF_BITS - 1);
    localparam logic signed [P_W-1:0] HALF_G  = P_W'(1) << (GAIN_FRAC - 1);
    localparam logic signed [P_W-1:0] SMP_MAX = (P_W'(1) << (SAMPLE_BITS - 1)) - P_W'(1);
    localparam logic signed [P_W-1:0] SMP_MIN = ~SMP_MAX;

    logic signed [DATA_W-1:0] r_sec_low  [STAGES];
    logic signed [DATA_W-1:0] r_sec_band [STAGES];

    logic signed [DATA_W-1:0]      r_x;
    logic signed [DATA_W-1:0]      r_lo;
    logic signed [DATA_W-1:0]      r_hi;
    logic signed [DATA_W-1:0]      r_nt;
    logic signed [SUM_W-1:0]       r_xs;
    logic signed [P_W-1:0]         r_prod;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_clip;

    logic [MA_W-1:0]          w_mul_a;
    logic signed [DATA_W-1:0] w_mul_b;
    logic signed [DATA_W-1:0] w_band_old;
    logic signed [DATA_W-1:0] w_low_old;
    logic signed [P_W-1:0]    w_sum_c;
    logic signed [P_W-1:0]    w_sh_c;
    logic signed [SUM_W-1:0]  w_rc;
    logic signed [DATA_W-1:0] w_band_new;
    logic signed [DATA_W-1:0] w_tap;
    logic signed [P_W-1:0]    w_sum_g;
    logic signed [P_W-1:0]    w_y;

    assign w_band_old = r_sec_band[i_stage];
    assign w_low_old  = r_sec_low[i_stage];

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_F_BAND: begin
                w_mul_a = MA_W'(i_coef_f);
                w_mul_b = w_band_old;
            end
            MUL_QS_X: begin
                w_mul_a = MA_W'(i_coef_q_sqrt);
                w_mul_b = r_x;
            end
            MUL_Q_BAND: begin
                w_mul_a = MA_W'(i_coef_q);
                w_mul_b = w_band_old;
            end
            MUL_F_HIGH: begin
                w_mul_a = MA_W'(i_coef_f);
                w_mul_b = r_hi;
            end
            default: begin
                w_mul_a = MA_W'(i_gain);
                w_mul_b = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= $signed({1'b0, w_mul_a}) * w_mul_b;
        end
    end

    // coefficient product, rounded half up
    assign w_sum_c    = r_prod + HALF_C;
    assign w_sh_c     = w_sum_c >>> COEF_BITS;
    assign w_rc       = w_sh_c[SUM_W-1:0];
    assign w_band_new = sat32(w_rc + sx(w_band_old));

    always_comb begin
        case (i_filter_type)
            FT_LOW:  w_tap = r_lo;
            FT_HIGH: w_tap = r_hi;
            FT_BAND: w_tap = w_band_new;
            default: w_tap = r_nt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= DATA_W'(i_sample_in);
        end
        unique case (i_cmd.op)
            OP_LOW:   r_lo <= sat32(sx(w_low_old) + w_rc);
            OP_XSCL:  r_xs <= w_rc;
            OP_HIGH:  r_hi <= sat32(r_xs - sx(r_lo) - w_rc);
            OP_NOTCH: r_nt <= sat32(sx(r_hi) + sx(r_lo));
            OP_BAND:  r_x  <= w_tap;
            default: begin
            end
        endcase
    end

    // section state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < STAGES; i++) begin
                r_sec_low[i]  <= '0;
                r_sec_band[i] <= '0;
            end
        end else if (i_cmd.op == OP_BAND) begin
            r_sec_low[i_stage]  <= r_lo;
            r_sec_band[i_stage] <= w_band_new;
        end
    end

    // gain, rounding and saturation into the output register
    assign w_sum_g = r_prod + HALF_G;
    assign w_y     = w_sum_g >>> GAIN_FRAC;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (w_y > SMP_MAX) begin
                r_out_sample <= SMP_MAX[SAMPLE_BITS-1:0];
                r_out_clip   <= 1'b1;
            end else if (w_y < SMP_MIN) begin
                r_out_sample <= SMP_MIN[SAMPLE_BITS-1:0];
                r_out_clip   <= 1'b1;
            end else begin
                r_out_sample <= w_y[SAMPLE_BITS-1:0];
                r_out_clip   <= 1'b0;
            end
        end
    end

    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clip;

endmodule

### hw/rtl/cascaded_state_variable_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_state_variable_filter
// Each input beat runs six dependent steps per section around one registered
// shared multiplier, then the gain product and the output load; the input
// stalls until the sequencer is back in idle, so a new sample is taken only
// after the last one is loaded into the output register.
// The output register frees the input side while a result waits.
// Synchronous active-low reset clears the sequencer, config and section state.
// ----------------------------------------------------------------------------
// Chain of state-variable sections with tap select, gain and saturation.
// ----------------------------------------------------------------------------
module cascaded_state_variable_filter import csvf_pkg::*; #(
    parameter int STAGES      = 5,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]              i_sample_in,
    output logic                                       o_out_valid,
    input  logic                                       i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]              o_sample_out,
    output logic                                       o_clipped,
    input  logic                                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                       i_cfg_index,
    input  logic [((COEF_BITS > 16) ? COEF_BITS : 16)-1:0] i_cfg_data
);

    localparam int IDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic [1:0]           w_filter_type;
    logic [IDX_W-1:0]     w_last_stage;
    logic [IDX_W-1:0]     w_stage;
    logic [COEF_BITS-1:0] w_coef_f;
    logic [COEF_BITS-1:0] w_coef_q;
    logic [COEF_BITS-1:0] w_coef_q_sqrt;
    logic [GAIN_W-1:0]    w_gain;
    logic                 w_clear;
    t_dp_cmd              w_cmd;

    csvf_regs #(
        .STAGES    (STAGES),
        .IDX_W     (IDX_W),
        .COEF_BITS (COEF_BITS)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_filter_type (w_filter_type),
        .o_last_stage  (w_last_stage),
        .o_coef_f      (w_coef_f),
        .o_coef_q      (w_coef_q),
        .o_coef_q_sqrt (w_coef_q_sqrt),
        .o_gain        (w_gain),
        .o_clear       (w_clear)
    );

    csvf_ctrl #(
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_last_stage (w_last_stage),
        .o_stage      (w_stage),
        .o_cmd        (w_cmd)
    );

    csvf_dp #(
        .STAGES      (STAGES),
        .IDX_W       (IDX_W),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_stage       (w_stage),
        .i_clear       (w_clear),
        .i_filter_type (w_filter_type),
        .i_coef_f      (w_coef_f),
        .i_coef_q      (w_coef_q),
        .i_coef_q_sqrt (w_coef_q_sqrt),
        .i_gain        (w_gain),
        .i_sample_in   (i_sample_in),
        .o_sample_out  (o_sample_out),
        .o_clipped     (o_clipped)
    );

`ifndef SYNTHESIS
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("output register overwritten while held");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("output valid without result load");
`endif

endmodule

### tb/tb_cascaded_state_variable_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cascaded_state_variable_filter
// Self-checking bench for the cascaded state-variable filter. A table of
// directed beats and register writes covers the taps, the stage count limits,
// the tuning coefficient limit, masked and ignored writes and gain saturation.
// Random retuning follows, each setting driving a burst of random samples.
// A bit-accurate predictor computes every output beat, and a monitor compares
// each output beat with the oldest prediction while both ports idle at random.
// ----------------------------------------------------------------------------
module tb_cascaded_state_variable_filter;
    import csvf_pkg::*;

    localparam int STAGES      = 5;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 18;
    localparam int CFG_W       = (COEF_BITS > 16) ? COEF_BITS : 16;
    localparam int DRAIN_WAIT  = 6 * STAGES + 10;

    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

    localparam logic [COEF_BITS-1:0] F_LIMIT = COEF_BITS'((1 << COEF_BITS) - 3);
    localparam longint SMP_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_MIN = -SMP_MAX - 1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          clip;
    } t_filt_out;

    typedef enum logic {ROW_SAMPLE, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [CFG_IDX_W-1:0]          idx;
        logic [CFG_W-1:0]              data;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          lit;
        logic signed [SAMPLE_BITS-1:0] lit_smp;
        logic                          lit_clip;
    } t_dir_row;

    localparam int DIR_ROWS = 42;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd0, 1'b1, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd8388607, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, -24'sd8388608, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd12345, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_FILTER_TYPE, 18'(FT_HIGH), 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd1000, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_FILTER_TYPE, 18'(FT_BAND), 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, -24'sd1000, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_FILTER_TYPE, 18'(FT_NOTCH), 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd5000, 1'b0, 24'sd0, 1'b0},
        // upper bits dropped, leaves the lowpass tap
        '{ROW_REG, REG_FILTER_TYPE, 18'h3FFFC, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd7, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_STAGE_COUNT, 18'd0, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd100, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_STAGE_COUNT, 18'd7, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd8388607, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, -24'sd8388608, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_STAGE_COUNT, 18'd5, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd4242, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_COEF_F, 18'd262143, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd8388607, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_COEF_F, 18'd0, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd3, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_NONE_LO, 18'h3FFFF, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_NONE_HI, 18'h00001, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd99, 1'b0, 24'sd0, 1'b0},
        // fresh single highpass section, f held at zero, full gain
        '{ROW_REG, REG_STAGE_COUNT, 18'd1, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_FILTER_TYPE, 18'(FT_HIGH), 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_COEF_Q_SQRT, 18'd262143, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_COEF_Q, 18'd262143, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_GAIN, 18'd65535, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd8388607, 1'b1, 24'sd8388607, 1'b1},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, -24'sd8388608, 1'b1, -24'sd8388608, 1'b1},
        '{ROW_REG, REG_GAIN, 18'd0, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd8388607, 1'b1, 24'sd0, 1'b0},
        '{ROW_REG, REG_GAIN, 18'h3FFFF, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, 24'sd1, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_COEF_F, 18'd26214, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_COEF_Q, 18'd131072, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_COEF_Q_SQRT, 18'd185364, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_REG, REG_GAIN, 18'd4096, 24'sd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, REG_FILTER_TYPE, 18'd0, -24'sd1, 1'b0, 24'sd0, 1'b0}
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample_in;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic                          o_clipped;
    logic                          i_cfg_we;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_W-1:0]              i_cfg_data;

    cascaded_state_variable_filter #(
        .STAGES      (STAGES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // predictor copy of the registers and section state
    logic [1:0]           tap_sel;
    logic [2:0]           stage_sel;
    logic [COEF_BITS-1:0] tune_f;
    logic [COEF_BITS-1:0] damp_q;
    logic [COEF_BITS-1:0] damp_q_sqrt;
    logic [GAIN_W-1:0]    out_gain;
    int                   sect_low  [STAGES];
    int                   sect_band [STAGES];

    t_filt_out pending_out[$];
    int        mismatch_count;
    int        send_idle;
    int        recv_idle;

    function automatic longint round_shr(input longint p, input int sh);
        return (p + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp32(input longint v);
        longint r;
        r = v;
        if (v > longint'(32'sh7FFFFFFF)) r = longint'(32'sh7FFFFFFF);
        if (v < -longint'(32'sh7FFFFFFF) - 1) r = -longint'(32'sh7FFFFFFF) - 1;
        return r;
    endfunction

    function automatic longint coef_mul(input logic [COEF_BITS-1:0] c, input longint v);
        return round_shr(longint'(c) * v, COEF_BITS);
    endfunction

    task automatic clear_sections();
        for (int i = 0; i < STAGES; i++) begin
            sect_low[i]  = 0;
            sect_band[i] = 0;
        end
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        case (idx)
            REG_FILTER_TYPE: tap_sel = d[1:0];
            REG_STAGE_COUNT: begin
                stage_sel = d[2:0];
                clear_sections();
            end
            REG_COEF_F:      tune_f = d[COEF_BITS-1:0];
            REG_COEF_Q:      damp_q = d[COEF_BITS-1:0];
            REG_COEF_Q_SQRT: damp_q_sqrt = d[COEF_BITS-1:0];
            REG_GAIN:        out_gain = d[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    function automatic t_filt_out svf_predict(input logic signed [SAMPLE_BITS-1:0] s);
        longint               x;
        longint               lo;
        longint               bd;
        longint               hi;
        longint               nt;
        longint               y;
        int                   n;
        logic [COEF_BITS-1:0] f;
        t_filt_out            r;
        f = (tune_f > F_LIMIT) ? F_LIMIT : tune_f;
        x = longint'(s);
        n = (stage_sel == 0) ? 1 : ((stage_sel > STAGES) ? STAGES : int'(stage_sel));
        for (int i = 0; i < n; i++) begin
            lo = clamp32(longint'(sect_low[i]) + coef_mul(f, longint'(sect_band[i])));
            hi = clamp32(coef_mul(damp_q_sqrt, x) - lo
                         - coef_mul(damp_q, longint'(sect_band[i])));
            bd = clamp32(coef_mul(f, hi) + longint'(sect_band[i]));
            nt = clamp32(hi + lo);
            sect_low[i]  = int'(lo);
            sect_band[i] = int'(bd);
            case (tap_sel)
                FT_LOW:  x = lo;
                FT_HIGH: x = hi;
                FT_BAND: x = bd;
                default: x = nt;
            endcase
        end
        y = round_shr(x * longint'(out_gain), GAIN_FRAC);
        r.clip = 1'b0;
        if (y > SMP_MAX) begin
            y = SMP_MAX;
            r.clip = 1'b1;
        end
        if (y < SMP_MIN) begin
            y = SMP_MIN;
            r.clip = 1'b1;
        end
        r.smp = y[SAMPLE_BITS-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic put_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic lit,
                              input t_filt_out lit_res);
        t_filt_out res;
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (o_in_stall);
        res = svf_predict(s);
        pending_out.push_back(lit ? lit_res : res);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        apply_reg(idx, d);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end

    // output side: random stall, compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        t_filt_out want;
        i_out_stall <= ($urandom_range(99) < recv_idle);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_out.size() == 0) begin
                report_mismatch("unexpected beat", longint'(o_sample_out), 0);
            end else begin
                want = pending_out.pop_front();
                if (o_sample_out !== want.smp) begin
                    report_mismatch("sample_out", longint'(o_sample_out), longint'(want.smp));
                end
                if (o_clipped !== want.clip) begin
                    report_mismatch("clipped", longint'(o_clipped), longint'(want.clip));
                end
            end
        end
    end

    initial begin
        int                            sent;
        int                            seg;
        logic signed [SAMPLE_BITS-1:0] s;
        logic [CFG_W-1:0]              d;
        t_dir_row                      row;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_sample_in    = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        mismatch_count = 0;
        send_idle      = 17;
        recv_idle      = 82;

        tap_sel     = FT_LOW;
        stage_sel   = 3'd1;
        tune_f      = 18'd26214;
        damp_q      = 18'd131072;
        damp_q_sqrt = 18'd185364;
        out_gain    = 16'd4096;
        clear_sections();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TAB[r];
            if (row.kind == ROW_REG) begin
                wait_idle();
                write_reg(row.idx, row.data);
            end else begin
                put_sample(row.smp, row.lit, '{smp: row.lit_smp, clip: row.lit_clip});
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle = 17;
                    recv_idle = 82;
                end
                1: begin
                    send_idle = 82;
                    recv_idle = 17;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            sent = 0;
            while (sent < 220) begin
                wait_idle();
                d = ($urandom_range(1) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(3));
                write_reg(REG_FILTER_TYPE, d);
                d = ($urandom_range(9) < 8) ? CFG_W'($urandom_range(5, 1))
                                            : CFG_W'($urandom_range(7));
                write_reg(REG_STAGE_COUNT, d);
                case ($urandom_range(4))
                    0: d = '0;
                    1: d = CFG_W'(F_LIMIT);
                    2: d = '1;
                    3: d = CFG_W'($urandom);
                    default: d = CFG_W'($urandom_range(40000));
                endcase
                write_reg(REG_COEF_F, d);
                case ($urandom_range(3))
                    0: d = '0;
                    1: d = '1;
                    2: d = CFG_W'($urandom);
                    default: d = CFG_W'($urandom_range(200000, 20000));
                endcase
                write_reg(REG_COEF_Q, d);
                case ($urandom_range(3))
                    0: d = '0;
                    1: d = '1;
                    2: d = CFG_W'($urandom);
                    default: d = CFG_W'($urandom_range(200000, 20000));
                endcase
                write_reg(REG_COEF_Q_SQRT, d);
                case ($urandom_range(4))
                    0: d = '0;
                    1: d = CFG_W'(16'hFFFF);
                    2: d = CFG_W'(16'd4096);
                    3: d = CFG_W'($urandom_range(16'hFFFF));
                    default: d = CFG_W'($urandom);
                endcase
                write_reg(REG_GAIN, d);
                if ($urandom_range(3) == 0) begin
                    write_reg($urandom_range(1) ? REG_NONE_HI : REG_NONE_LO, CFG_W'($urandom));
                end
                seg = $urandom_range(80, 30);
                for (int k = 0; k < seg; k++) begin
                    case ($urandom_range(9))
                        0: s = SAMPLE_BITS'(SMP_MAX);
                        1: s = SAMPLE_BITS'(SMP_MIN);
                        2: s = SAMPLE_BITS'($signed($urandom_range(512)) - 256);
                        default: s = SAMPLE_BITS'($urandom);
                    endcase
                    put_sample(s, 1'b0, '0);
                end
                sent += seg;
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
